@@ sv/rbp_pkg.sv @@
// Package for the raster bitmap packer: configuration indexes, header bytes and threshold.
package rbp_pkg;

    localparam int unsigned PixelWidth = 24;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned DimWidth   = 16;
    localparam int unsigned HdrCount   = 8;
    localparam int unsigned HdrIdxWidth = $clog2(HdrCount);

    localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [7:0] HDR_GS  = 8'h1D;
    localparam logic [7:0] HDR_V   = 8'h76;
    localparam logic [7:0] HDR_ZRO = 8'h30;
    localparam logic [7:0] HDR_MODE = 8'h00;

    localparam logic [9:0]  LUMA_R = 10'd299;
    localparam logic [9:0]  LUMA_G = 10'd587;
    localparam logic [9:0]  LUMA_B = 10'd114;
    localparam logic [18:0] LUMA_THRESHOLD = 19'd128000;

    localparam logic [HdrIdxWidth-1:0] HDR_LAST = HdrIdxWidth'(HdrCount - 1);

    typedef logic [HdrIdxWidth-1:0] hdr_idx_t;

    function automatic logic [7:0] hdr_byte(input hdr_idx_t idx,
                                            input logic [13:0] row_bytes,
                                            input logic [DimWidth-1:0] height);
        logic [7:0] b;
        begin
            case (idx)
                3'd0:    b = HDR_GS;
                3'd1:    b = HDR_V;
                3'd2:    b = HDR_ZRO;
                3'd3:    b = HDR_MODE;
                3'd4:    b = row_bytes[7:0];
                3'd5:    b = {2'b00, row_bytes[13:8]};
                3'd6:    b = height[7:0];
                default: b = height[15:8];
            endcase
            return b;
        end
    endfunction

endpackage

@@ sv/raster_bitmap_packer_core.sv @@
// Raster bitmap packer: RGB pixels in, raster print command bytes out.
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_tvalid / s_tready    | s_tdata[23:0] pixel_rgb
//  m_      | out       | m_tvalid / m_tready    | m_tdata out_byte, m_tlast run_last,
//          |           |                        | m_tuser image_end
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pixel per cycle while m_tready does not stall; a pixel that gives one byte or none
// keeps s_tready high. The first pixel of an image sends the eight header bytes, then
// its data byte if it fills or ends one; s_tready stays low until the last is loaded.
// Synchronous active-low reset clears the counters, the item and output valid flags.
// m_tready low holds the output register and, once the item register is full, s_tready.
module raster_bitmap_packer_core
    import rbp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PixelWidth-1:0] s_tdata,   // [23:0] pixel_rgb
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ByteWidth-1:0]  m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,
    output logic                  m_tuser,   // [0] image_end
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [DimWidth-1:0]   cfg_data
);

    logic [DimWidth-1:0] width_reg, height_reg;
    logic [DimWidth-1:0] col_reg, col_next;
    logic [DimWidth-1:0] row_reg, row_next;
    logic [2:0]          bitpos_reg, bitpos_next;
    logic [7:0]          partial_reg, partial_next;
    logic                hsent_reg, hsent_next;

    logic                job_valid_reg, job_valid_next;
    logic                job_hdr_reg, job_hdr_next;
    hdr_idx_t            job_idx_reg, job_idx_next;
    logic                job_data_reg, job_data_next;
    logic [7:0]          job_byte_reg, job_byte_next;
    logic                job_end_reg, job_end_next;

    logic                m_tvalid_reg;
    logic [7:0]          m_byte_reg;
    logic                m_last_reg, m_user_reg;

    logic [DimWidth-1:0] w_eff, h_eff;
    logic [13:0]         row_bytes;
    logic [DimWidth-1:0] col_base, row_base;
    logic [2:0]          bit_base;
    logic [7:0]          part_base, part_set;
    logic [18:0]         luma;
    logic                black, col_end, img_end, byte_out, accept;
    logic                out_load, out_last, job_done;
    logic [7:0]          out_byte;
    logic                out_user;

    assign cfg_ready = 1'b1;

    always_comb begin
        w_eff     = (width_reg == '0) ? DimWidth'(1) : width_reg;
        h_eff     = (height_reg == '0) ? DimWidth'(1) : height_reg;
        row_bytes = 14'(({1'b0, w_eff} + 17'd7) >> 3);
    end

    always_comb begin
        luma = 19'(LUMA_R) * 19'(s_tdata[23:16]) + 19'(LUMA_G) * 19'(s_tdata[15:8])
             + 19'(LUMA_B) * 19'(s_tdata[7:0]);
        black = luma < LUMA_THRESHOLD;
        col_base  = hsent_reg ? col_reg : '0;
        row_base  = hsent_reg ? row_reg : '0;
        bit_base  = hsent_reg ? bitpos_reg : 3'd0;
        part_base = hsent_reg ? partial_reg : 8'd0;
        part_set  = part_base | (black ? (8'h80 >> bit_base) : 8'h00);
        col_end   = ({1'b0, col_base} + 17'd1) >= {1'b0, w_eff};
        img_end   = ({1'b0, row_base} + 17'd1) >= {1'b0, h_eff};
        byte_out  = col_end || (bit_base == 3'd7);
    end

    always_comb begin
        out_load = job_valid_reg && (!m_tvalid_reg || m_tready);
        if (job_hdr_reg) begin
            out_byte = hdr_byte(job_idx_reg, row_bytes, h_eff);
            out_last = (job_idx_reg == HDR_LAST) && !job_data_reg;
            out_user = 1'b0;
        end else begin
            out_byte = job_byte_reg;
            out_last = 1'b1;
            out_user = job_end_reg;
        end
        job_done = out_load && out_last;
        s_tready = !job_valid_reg || job_done;
        accept   = s_tvalid && s_tready;
    end

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        bitpos_next  = bitpos_reg;
        partial_next = partial_reg;
        hsent_next   = hsent_reg;
        if (accept) begin
            hsent_next = 1'b1;
            if (col_end) begin
                partial_next = 8'd0;
                bitpos_next  = 3'd0;
                col_next     = '0;
                if (img_end) begin
                    row_next   = '0;
                    hsent_next = 1'b0;
                end else begin
                    row_next = row_base + DimWidth'(1);
                end
            end else begin
                col_next = col_base + DimWidth'(1);
                row_next = row_base;
                if (bit_base == 3'd7) begin
                    partial_next = 8'd0;
                    bitpos_next  = 3'd0;
                end else begin
                    partial_next = part_set;
                    bitpos_next  = bit_base + 3'd1;
                end
            end
        end
    end

    always_comb begin
        job_valid_next = job_valid_reg;
        job_hdr_next   = job_hdr_reg;
        job_idx_next   = job_idx_reg;
        job_data_next  = job_data_reg;
        job_byte_next  = job_byte_reg;
        job_end_next   = job_end_reg;
        if (accept) begin
            job_valid_next = !hsent_reg || byte_out;
            job_hdr_next   = !hsent_reg;
            job_idx_next   = '0;
            job_data_next  = byte_out;
            job_byte_next  = part_set;
            job_end_next   = col_end && img_end;
        end else if (job_done) begin
            job_valid_next = 1'b0;
        end else if (out_load && job_hdr_reg) begin
            if (job_idx_reg == HDR_LAST) begin
                job_hdr_next = 1'b0;
            end else begin
                job_idx_next = job_idx_reg + hdr_idx_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= DimWidth'(1);
            height_reg    <= DimWidth'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            bitpos_reg    <= 3'd0;
            partial_reg   <= 8'd0;
            hsent_reg     <= 1'b0;
            job_valid_reg <= 1'b0;
            job_hdr_reg   <= 1'b0;
            job_idx_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            bitpos_reg    <= bitpos_next;
            partial_reg   <= partial_next;
            hsent_reg     <= hsent_next;
            job_valid_reg <= job_valid_next;
            job_hdr_reg   <= job_hdr_next;
            job_idx_reg   <= job_idx_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_data_reg <= job_data_next;
        job_byte_reg <= job_byte_next;
        job_end_reg  <= job_end_next;
        if (out_load) begin
            m_byte_reg <= out_byte;
            m_last_reg <= out_last;
            m_user_reg <= out_user;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule
